/* hdl/rpc_pkg.sv */
package rpc_pkg;

    // Fixed field widths
    localparam int COORD_W    = 24;
    localparam int CSUM_W     = 25;
    localparam int DIFF_W     = 27;   // 2*point - centre sum, half-LSB units
    localparam int ROT_W      = 30;   // rotated coordinate, headroom for sqrt(3) growth
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int NUM_AXES   = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // Sine table generation: Q30 Taylor series
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam int          SINE_Q      = 30;
    localparam int          TAYLOR_LAST = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CSUM_X  = 3'd0,
        REG_CSUM_Y  = 3'd1,
        REG_CSUM_Z  = 3'd2,
        REG_ANGLE_X = 3'd3,
        REG_ANGLE_Y = 3'd4,
        REG_ANGLE_Z = 3'd5
    } t_reg_idx;

    // Centred point as it travels from front to back
    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } t_pt;

    // Quarter-wave entry k: round(sin(k*pi/2^(abits-1)) * 2^tbits), clamped.
    // Elaboration only.
    function automatic logic [31:0] sine_entry(input int k, input int abits, input int tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      res;
        x    = (64'(k) * PI_Q30) >> (abits - 1);
        x2   = (x * x) >> SINE_Q;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n < TAYLOR_LAST; n += 2) begin
            term = ((term * x2) >> SINE_Q) / 64'((n + 1) * (n + 2));
            if ((((n + 1) / 2) % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        res = (sum + (longint'(1) << (SINE_Q - 1 - tbits))) >>> (SINE_Q - tbits);
        if (res > (longint'(1) << tbits)) begin
            res = longint'(1) << tbits;
        end
        return res[31:0];
    endfunction

endpackage

/* hdl/rpc_if.sv */
interface rpc_pt_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rpc_pkg::COORD_W-1:0]       x_in;
    logic signed [rpc_pkg::COORD_W-1:0]       y_in;
    logic signed [rpc_pkg::COORD_W-1:0]       z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface rpc_res_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rpc_pkg::COORD_W-1:0]       x_out;
    logic signed [rpc_pkg::COORD_W-1:0]       y_out;
    logic signed [rpc_pkg::COORD_W-1:0]       z_out;
    logic                                     saturated;

    modport source (output valid, output x_out, output y_out, output z_out,
                    output saturated, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out,
                    input saturated, output ready);
endinterface

interface rpc_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [rpc_pkg::CFG_IDX_W-1:0]            index;
    logic [rpc_pkg::CFG_DATA_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/rpc_front.sv */
module rpc_front #(
    parameter int ANGLE_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    rpc_pt_if.sink                                  i_pt,
    rpc_cfg_if.sink                                 i_cfg,
    input  logic                                    i_q_full,
    output logic                                    o_push,
    output rpc_pkg::t_pt                            o_pt,
    output logic signed [TRIG_FRAC_BITS+1:0]        o_cos  [rpc_pkg::NUM_AXES],
    output logic signed [TRIG_FRAC_BITS+1:0]        o_sin  [rpc_pkg::NUM_AXES],
    output logic signed [rpc_pkg::CSUM_W-1:0]       o_csum [rpc_pkg::NUM_AXES]
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int ROM_N   = QUARTER + 1;
    localparam int IW      = ANGLE_BITS - 1;
    localparam int TW      = TRIG_FRAC_BITS + 1;
    localparam int SW      = TW + 1;
    localparam int STEPS   = 2 * rpc_pkg::NUM_AXES;
    localparam int STEP_W  = $clog2(STEPS);

    typedef logic [TW-1:0] t_rom [ROM_N];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < ROM_N; k++) begin
            rom[k] = TW'(rpc_pkg::sine_entry(k, ANGLE_BITS, TRIG_FRAC_BITS));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // config registers
    logic signed [rpc_pkg::CSUM_W-1:0] r_csum  [rpc_pkg::NUM_AXES];
    logic        [ANGLE_BITS-1:0]      r_angle [rpc_pkg::NUM_AXES];

    // trig refresh sequencer
    logic                      r_busy;
    logic [STEP_W-1:0]         r_step;
    logic                      r_lk_vld;
    logic [STEP_W-1:0]         r_lk_step;
    logic                      r_lk_neg;
    logic [TW-1:0]             r_rom_q;
    logic signed [SW-1:0]      r_cos [rpc_pkg::NUM_AXES];
    logic signed [SW-1:0]      r_sin [rpc_pkg::NUM_AXES];

    logic [ANGLE_BITS-1:0]     lk_ang;
    logic [1:0]                lk_quad;
    logic [IW-1:0]             lk_idx;
    logic signed [SW-1:0]      lk_val;

    // centring stage
    logic                      r_fvld;
    rpc_pkg::t_pt              r_pt;
    rpc_pkg::t_pt              n_pt;
    logic                      pt_acc;
    logic                      cfg_acc;

    assign cfg_acc     = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_pt.ready  = ~r_busy & ~r_lk_vld & (~r_fvld | ~i_q_full);
    assign pt_acc      = i_pt.valid & i_pt.ready;
    assign o_push      = r_fvld & ~i_q_full;
    assign o_pt        = r_pt;

    // quarter-wave folding; cos = sin(a + quarter turn)
    always_comb begin
        lk_ang  = r_angle[r_step[STEP_W-1:1]]
                + (r_step[0] ? ANGLE_BITS'(QUARTER) : '0);
        lk_quad = lk_ang[ANGLE_BITS-1:ANGLE_BITS-2];
        lk_idx  = lk_quad[0] ? IW'(QUARTER) - IW'(lk_ang[ANGLE_BITS-3:0])
                             : IW'(lk_ang[ANGLE_BITS-3:0]);
        lk_val  = r_lk_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});
    end

    // d = 2*p - csum keeps the half-centre exact
    always_comb begin
        n_pt.x = (rpc_pkg::DIFF_W'(i_pt.x_in) <<< 1) - rpc_pkg::DIFF_W'(r_csum[0]);
        n_pt.y = (rpc_pkg::DIFF_W'(i_pt.y_in) <<< 1) - rpc_pkg::DIFF_W'(r_csum[1]);
        n_pt.z = (rpc_pkg::DIFF_W'(i_pt.z_in) <<< 1) - rpc_pkg::DIFF_W'(r_csum[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_step   <= '0;
            r_lk_vld <= 1'b0;
            r_fvld   <= 1'b0;
            for (int a = 0; a < rpc_pkg::NUM_AXES; a++) begin
                r_csum[a]  <= '0;
                r_angle[a] <= '0;
            end
        end else begin
            if (cfg_acc) begin
                unique case (rpc_pkg::t_reg_idx'(i_cfg.index))
                    rpc_pkg::REG_CSUM_X:  r_csum[0]  <= $signed(i_cfg.data);
                    rpc_pkg::REG_CSUM_Y:  r_csum[1]  <= $signed(i_cfg.data);
                    rpc_pkg::REG_CSUM_Z:  r_csum[2]  <= $signed(i_cfg.data);
                    rpc_pkg::REG_ANGLE_X: r_angle[0] <= i_cfg.data[ANGLE_BITS-1:0];
                    rpc_pkg::REG_ANGLE_Y: r_angle[1] <= i_cfg.data[ANGLE_BITS-1:0];
                    rpc_pkg::REG_ANGLE_Z: r_angle[2] <= i_cfg.data[ANGLE_BITS-1:0];
                    default: ;
                endcase
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            r_lk_vld <= r_busy;

            if (pt_acc) begin
                r_fvld <= 1'b1;
            end else if (o_push) begin
                r_fvld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lk_step <= r_step;
        r_lk_neg  <= lk_quad[1];
        r_rom_q   <= SINE_ROM[lk_idx];
        if (r_lk_vld) begin
            if (r_lk_step[0]) begin
                r_cos[r_lk_step[STEP_W-1:1]] <= lk_val;
            end else begin
                r_sin[r_lk_step[STEP_W-1:1]] <= lk_val;
            end
        end
        if (pt_acc) begin
            r_pt <= n_pt;
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_csum = r_csum;

endmodule

/* hdl/rpc_queue.sv */
module rpc_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  rpc_pkg::t_pt i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output rpc_pkg::t_pt o_data
);

    rpc_pkg::t_pt              r_mem [rpc_pkg::QUEUE_DEPTH];
    logic [rpc_pkg::QPTR_W-1:0] r_wr;
    logic [rpc_pkg::QPTR_W-1:0] r_rd;
    logic [rpc_pkg::QPTR_W:0]   r_cnt;
    logic                       do_push;
    logic                       do_pop;

    assign o_full  = (r_cnt == (rpc_pkg::QPTR_W + 1)'(rpc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/rpc_back.sv */
module rpc_back #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  rpc_pkg::t_pt                       i_q_pt,
    output logic                               o_pop,
    input  logic signed [TRIG_FRAC_BITS+1:0]   i_cos  [rpc_pkg::NUM_AXES],
    input  logic signed [TRIG_FRAC_BITS+1:0]   i_sin  [rpc_pkg::NUM_AXES],
    input  logic signed [rpc_pkg::CSUM_W-1:0]  i_csum [rpc_pkg::NUM_AXES],
    rpc_res_if.source                          o_res
);

    localparam int SW   = TRIG_FRAC_BITS + 2;
    localparam int CW   = rpc_pkg::ROT_W;
    localparam int PW   = CW + SW;
    localparam int SUMW = PW + 1;
    localparam int FW   = CW + 1;
    localparam int NSTG = 7;
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (TRIG_FRAC_BITS - 1);
    localparam logic signed [FW-1:0]   SAT_HI = FW'(rpc_pkg::COORD_MAX);
    localparam logic signed [FW-1:0]   SAT_LO = FW'(rpc_pkg::COORD_MIN);

    function automatic logic signed [PW-1:0] mul(input logic signed [CW-1:0] a,
                                                 input logic signed [SW-1:0] b);
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] be;
        ae = PW'(a);
        be = PW'(b);
        return ae * be;
    endfunction

    // (a +/- b + half) floor-shifted by the trig fraction
    function automatic logic signed [CW-1:0] rnd(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b,
                                                 input logic sub);
        logic signed [SUMW-1:0] s;
        s = sub ? (SUMW'(a) - SUMW'(b)) : (SUMW'(a) + SUMW'(b));
        s = s + HALF;
        return CW'(s >>> TRIG_FRAC_BITS);
    endfunction

    logic [NSTG-1:0]                    r_vld;
    logic                               en;

    logic signed [CW-1:0]               r_s0_x;
    logic signed [PW-1:0]               r_s0_p [4];
    logic signed [CW-1:0]               r_s1_x, r_s1_y, r_s1_z;
    logic signed [CW-1:0]               r_s2_y;
    logic signed [PW-1:0]               r_s2_p [4];
    logic signed [CW-1:0]               r_s3_x, r_s3_y, r_s3_z;
    logic signed [CW-1:0]               r_s4_z;
    logic signed [PW-1:0]               r_s4_p [4];
    logic signed [CW-1:0]               r_s5_c [rpc_pkg::NUM_AXES];
    logic signed [rpc_pkg::COORD_W-1:0] r_out  [rpc_pkg::NUM_AXES];
    logic                               r_sat;

    logic signed [FW-1:0]               fin_sum [rpc_pkg::NUM_AXES];
    logic signed [FW-1:0]               fin_v   [rpc_pkg::NUM_AXES];
    logic signed [rpc_pkg::COORD_W-1:0] n_out   [rpc_pkg::NUM_AXES];
    logic                               n_sat;

    // whole pipe moves when the output register is free or being drained
    assign en    = ~r_vld[NSTG-1] | o_res.ready;
    assign o_pop = en & i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_q_valid};
        end
    end

    // out = floor((r + csum + 1) / 2), clipped to 24 bits
    always_comb begin
        n_sat = 1'b0;
        for (int a = 0; a < rpc_pkg::NUM_AXES; a++) begin
            fin_sum[a] = FW'(r_s5_c[a]) + FW'(i_csum[a]) + FW'(1);
            fin_v[a]   = fin_sum[a] >>> 1;
            if (fin_v[a] > SAT_HI) begin
                n_out[a] = rpc_pkg::COORD_W'(SAT_HI);
                n_sat    = 1'b1;
            end else if (fin_v[a] < SAT_LO) begin
                n_out[a] = rpc_pkg::COORD_W'(SAT_LO);
                n_sat    = 1'b1;
            end else begin
                n_out[a] = rpc_pkg::COORD_W'(fin_v[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // about X: y' = y c - z s, z' = y s + z c
            r_s0_x    <= CW'(i_q_pt.x);
            r_s0_p[0] <= mul(CW'(i_q_pt.y), i_cos[0]);
            r_s0_p[1] <= mul(CW'(i_q_pt.z), i_sin[0]);
            r_s0_p[2] <= mul(CW'(i_q_pt.y), i_sin[0]);
            r_s0_p[3] <= mul(CW'(i_q_pt.z), i_cos[0]);

            r_s1_x <= r_s0_x;
            r_s1_y <= rnd(r_s0_p[0], r_s0_p[1], 1'b1);
            r_s1_z <= rnd(r_s0_p[2], r_s0_p[3], 1'b0);

            // about Y: x' = x c + z s, z' = z c - x s
            r_s2_y    <= r_s1_y;
            r_s2_p[0] <= mul(r_s1_x, i_cos[1]);
            r_s2_p[1] <= mul(r_s1_z, i_sin[1]);
            r_s2_p[2] <= mul(r_s1_z, i_cos[1]);
            r_s2_p[3] <= mul(r_s1_x, i_sin[1]);

            r_s3_y <= r_s2_y;
            r_s3_x <= rnd(r_s2_p[0], r_s2_p[1], 1'b0);
            r_s3_z <= rnd(r_s2_p[2], r_s2_p[3], 1'b1);

            // about Z: x' = x c - y s, y' = x s + y c
            r_s4_z    <= r_s3_z;
            r_s4_p[0] <= mul(r_s3_x, i_cos[2]);
            r_s4_p[1] <= mul(r_s3_y, i_sin[2]);
            r_s4_p[2] <= mul(r_s3_x, i_sin[2]);
            r_s4_p[3] <= mul(r_s3_y, i_cos[2]);

            r_s5_c[0] <= rnd(r_s4_p[0], r_s4_p[1], 1'b1);
            r_s5_c[1] <= rnd(r_s4_p[2], r_s4_p[3], 1'b0);
            r_s5_c[2] <= r_s4_z;

            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_res.valid     = r_vld[NSTG-1];
    assign o_res.x_out     = r_out[0];
    assign o_res.y_out     = r_out[1];
    assign o_res.z_out     = r_out[2];
    assign o_res.saturated = r_sat;

endmodule

/* hdl/rotate_point_about_center_xyz_top.sv */
// Throughput: one point per cycle, sustained outside trig refreshes; the
// seven-stage rotation pipe stalls only when the result is not taken.
// Reset (i_rst_n low, synchronous): centre sums and angles clear to 0, and the sine
// and cosine registers are refilled, input held off meanwhile.
// Any configuration write also refills the trig registers (input held off).
module rotate_point_about_center_xyz_top #(
    parameter int ANGLE_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpc_pt_if.sink     i_pt,
    rpc_res_if.source  o_res,
    rpc_cfg_if.sink    i_cfg
);

    // Front: config registers, trig refresh from the quarter-wave sine table
    // (one table read per cycle, sin and cos per axis), and the centring stage
    // d = 2*p - centre_sum, done at double resolution so half the centre is exact.
    // Queue: four entries of centred points; lets the front keep taking requests
    // while the back is held by its consumer.
    // Back: X, Y and Z rotations, each one multiply stage and one add/round stage,
    // then the recentring/saturation stage, which doubles as the output register.

    logic                               q_push;
    logic                               q_full;
    logic                               q_valid;
    logic                               q_pop;
    rpc_pkg::t_pt                       front_pt;
    rpc_pkg::t_pt                       q_pt;
    logic signed [TRIG_FRAC_BITS+1:0]   trig_cos [rpc_pkg::NUM_AXES];
    logic signed [TRIG_FRAC_BITS+1:0]   trig_sin [rpc_pkg::NUM_AXES];
    logic signed [rpc_pkg::CSUM_W-1:0]  csum     [rpc_pkg::NUM_AXES];

    rpc_front #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pt     (i_pt),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_pt     (front_pt),
        .o_cos    (trig_cos),
        .o_sin    (trig_sin),
        .o_csum   (csum)
    );

    rpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_pt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_pt)
    );

    // user holds centre sums, trig values static with requests in flight; unchecked
    rpc_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_pt    (q_pt),
        .o_pop     (q_pop),
        .i_cos     (trig_cos),
        .i_sin     (trig_sin),
        .i_csum    (csum),
        .o_res     (o_res)
    );

endmodule

/* tb/sv/rpc_rotation_checker.sv */
`timescale 1ns / 1ps

module rpc_rotation_checker #(
    parameter int ANGLE_BITS     = 12,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rpc_pt_if    i_pt,
    rpc_res_if   i_res,
    rpc_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_outstanding
);
    import rpc_pkg::*;

    localparam int QUARTER_TURN  = 1 << (ANGLE_BITS - 2);
    localparam int SERIES_Q      = 30;
    localparam int SERIES_END    = 21;
    localparam int REPORT_LIMIT  = 10;
    localparam int AX_X          = 0;
    localparam int AX_Y          = 1;
    localparam int AX_Z          = 2;
    localparam longint unsigned PI_FIXED = 64'd3373259426;  // pi in Q30

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      sat;
    } t_rot_result;

    logic signed [CSUM_W-1:0]     centre_sum [NUM_AXES];
    logic        [ANGLE_BITS-1:0] angle      [NUM_AXES];
    longint                       sine_rom   [0:QUARTER_TURN];
    t_rot_result                  expected_q [$];
    int                           mismatch_count;

    // Quarter-wave sine, Q30 Taylor series, rounded to TRIG_FRAC_BITS
    function automatic longint quarter_sine(input int k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        longint          rounded;
        bit              subtract;
        ang      = (64'(k) * PI_FIXED) >> (ANGLE_BITS - 1);
        ang_sq   = (ang * ang) >> SERIES_Q;
        term     = ang;
        acc      = longint'(ang);
        subtract = 1'b1;
        for (int n = 1; n < SERIES_END; n += 2) begin
            term = ((term * ang_sq) >> SERIES_Q) / 64'((n + 1) * (n + 2));
            acc  = subtract ? acc - longint'(term) : acc + longint'(term);
            subtract = !subtract;
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (acc + (64'sd1 << (SERIES_Q - 1 - TRIG_FRAC_BITS)))
                  >>> (SERIES_Q - TRIG_FRAC_BITS);
        if (rounded > (64'sd1 << TRIG_FRAC_BITS)) begin
            rounded = 64'sd1 << TRIG_FRAC_BITS;
        end
        return rounded;
    endfunction

    function automatic longint sine_at(input logic [ANGLE_BITS-1:0] a);
        logic [1:0] quadrant;
        int         offset;
        longint     mag;
        quadrant = a[ANGLE_BITS-1 -: 2];
        offset   = int'(a[ANGLE_BITS-3:0]);
        mag      = quadrant[0] ? sine_rom[QUARTER_TURN - offset] : sine_rom[offset];
        return quadrant[1] ? -mag : mag;
    endfunction

    function automatic longint cosine_at(input logic [ANGLE_BITS-1:0] a);
        return sine_at(a + ANGLE_BITS'(QUARTER_TURN));
    endfunction

    // round half up at the trig fraction
    function automatic longint trig_round(input longint v);
        return (v + (64'sd1 << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    endfunction

    function automatic t_rot_result predict_rotation(input logic signed [COORD_W-1:0] px,
                                                     input logic signed [COORD_W-1:0] py,
                                                     input logic signed [COORD_W-1:0] pz);
        longint      cs [NUM_AXES];
        longint      d  [NUM_AXES];
        longint      o  [NUM_AXES];
        longint      c, s, t0, t1;
        t_rot_result r;
        for (int i = 0; i < NUM_AXES; i++) begin
            cs[i] = longint'(centre_sum[i]);
        end
        // half-LSB units so half the centre sum is exact
        d[AX_X] = 2 * longint'(px) - cs[AX_X];
        d[AX_Y] = 2 * longint'(py) - cs[AX_Y];
        d[AX_Z] = 2 * longint'(pz) - cs[AX_Z];

        c = cosine_at(angle[AX_X]);
        s = sine_at(angle[AX_X]);
        t0 = trig_round(d[AX_Y] * c - d[AX_Z] * s);
        t1 = trig_round(d[AX_Y] * s + d[AX_Z] * c);
        d[AX_Y] = t0;
        d[AX_Z] = t1;

        c = cosine_at(angle[AX_Y]);
        s = sine_at(angle[AX_Y]);
        t0 = trig_round(d[AX_X] * c + d[AX_Z] * s);
        t1 = trig_round(d[AX_Z] * c - d[AX_X] * s);
        d[AX_X] = t0;
        d[AX_Z] = t1;

        c = cosine_at(angle[AX_Z]);
        s = sine_at(angle[AX_Z]);
        t0 = trig_round(d[AX_X] * c - d[AX_Y] * s);
        t1 = trig_round(d[AX_X] * s + d[AX_Y] * c);
        d[AX_X] = t0;
        d[AX_Y] = t1;

        r.sat = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            o[i] = (d[i] + cs[i] + 1) >>> 1;
            if (o[i] > COORD_MAX) begin
                o[i]  = COORD_MAX;
                r.sat = 1'b1;
            end else if (o[i] < COORD_MIN) begin
                o[i]  = COORD_MIN;
                r.sat = 1'b1;
            end
        end
        r.x = COORD_W'(o[AX_X]);
        r.y = COORD_W'(o[AX_Y]);
        r.z = COORD_W'(o[AX_Z]);
        return r;
    endfunction

    initial begin
        for (int k = 0; k <= QUARTER_TURN; k++) begin
            sine_rom[k] = quarter_sine(k);
        end
    end

    always @(posedge i_clk) begin
        t_rot_result want;
        t_rot_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                centre_sum[i] = '0;
                angle[i]      = '0;
            end
            expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_CSUM_X:  centre_sum[AX_X] = i_cfg.data[CSUM_W-1:0];
                    REG_CSUM_Y:  centre_sum[AX_Y] = i_cfg.data[CSUM_W-1:0];
                    REG_CSUM_Z:  centre_sum[AX_Z] = i_cfg.data[CSUM_W-1:0];
                    REG_ANGLE_X: angle[AX_X]      = i_cfg.data[ANGLE_BITS-1:0];
                    REG_ANGLE_Y: angle[AX_Y]      = i_cfg.data[ANGLE_BITS-1:0];
                    REG_ANGLE_Z: angle[AX_Z]      = i_cfg.data[ANGLE_BITS-1:0];
                    default: ;  // spare index, no effect
                endcase
            end
            if (i_pt.valid && i_pt.ready) begin
                expected_q.push_back(predict_rotation(i_pt.x_in, i_pt.y_in, i_pt.z_in));
            end
            if (i_res.valid && i_res.ready) begin
                got.x   = i_res.x_out;
                got.y   = i_res.y_out;
                got.z   = i_res.z_out;
                got.sat = i_res.saturated;
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                                 got.x, got.y, got.z, got.sat);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.z !== want.z || got.sat !== want.sat) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("mismatch: exp x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                                     want.x, want.y, want.z, want.sat,
                                     got.x, got.y, got.z, got.sat);
                        end
                    end
                end
            end
        end
        o_fail_count  <= mismatch_count;
        o_outstanding <= expected_q.size();
    end

endmodule

/* tb/sv/tb_rotate_point_about_center_xyz_top.sv */
`timescale 1ns / 1ps

module tb_rotate_point_about_center_xyz_top;
    import rpc_pkg::*;

    localparam int ANGLE_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 25;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int CALM_FROM     = 500;     // stretch with both sides always willing
    localparam int CALM_TO       = 850;
    localparam int DRAIN_CYCLES  = 24;      // longer than the request-to-result latency
    localparam int CYCLE_LIMIT   = 300000;
    localparam int ANGLE_QUARTER = 1 << (ANGLE_BITS - 2);

    // indexes past the register map; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // centre-sum extremes, plus the one pattern above the stated range
    localparam logic [CFG_DATA_W-1:0] CSUM_TOP    = CFG_DATA_W'(16777214);
    localparam logic [CFG_DATA_W-1:0] CSUM_BOTTOM = CFG_DATA_W'(-16777216);
    localparam logic [CFG_DATA_W-1:0] CSUM_ABOVE  = CFG_DATA_W'(16777215);
    localparam logic [CFG_DATA_W-1:0] CSUM_MINUS1 = '1;
    localparam logic [CFG_DATA_W-1:0] CSUM_ZERO   = '0;

    localparam logic signed [COORD_W-1:0] PT_MAX = COORD_W'(COORD_MAX);
    localparam logic signed [COORD_W-1:0] PT_MIN = COORD_W'(COORD_MIN);

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpc_pt_if  pt_if ();
    rpc_res_if res_if ();
    rpc_cfg_if cfg_if ();

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int points_sent = 0;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rotate_point_about_center_xyz_top #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Watches all three channels, predicts each result and compares
    rpc_rotation_checker #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotation_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pt          (pt_if),
        .i_res         (res_if),
        .i_cfg         (cfg_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Result side back-pressure: drops ready about a quarter of the time,
    // except during the calm stretch.
    initial res_if.ready = 1'b0;
    always @(negedge i_clk) begin
        res_if.ready <= snk_idle_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rotate_point_about_center_xyz_top test failed");
            $finish;
        end
    end

    // One register write; valid drops again at the next falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // One point request. Entered and left on a falling edge with valid still
    // high, so back-to-back requests keep valid up without a glitch.
    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [COORD_W-1:0] pz);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            pt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.x_in  <= px;
        pt_if.y_in  <= py;
        pt_if.z_in  <= pz;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        points_sent++;
    endtask

    // Close a burst and wait until every result is back, so the block is idle
    // before any register changes.
    task automatic settle();
        pt_if.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Coordinates: half small (keeps more results unclipped), with full-range
    // patterns and the two rails mixed in.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return PT_MAX;
            1:       return PT_MIN;
            2, 3, 4: return COORD_W'($urandom);
            default: return COORD_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_csum();
        case ($urandom_range(0, 7))
            0:       return CSUM_TOP;
            1:       return CSUM_BOTTOM;
            2, 3:    return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    // Angle word: junk above the angle bits, and a bias towards the quadrant
    // boundaries where the table folds.
    function automatic logic [CFG_DATA_W-1:0] rand_angle_word();
        logic [CFG_DATA_W-1:0] word;
        logic [ANGLE_BITS-1:0] a;
        case ($urandom_range(0, 5))
            0:       a = ANGLE_BITS'(ANGLE_QUARTER * $urandom_range(0, 3));
            1:       a = ANGLE_BITS'(ANGLE_QUARTER * $urandom_range(0, 3)
                                     + $urandom_range(0, 2) - 1);
            default: a = ANGLE_BITS'($urandom);
        endcase
        word = CFG_DATA_W'($urandom);
        word[ANGLE_BITS-1:0] = a;
        return word;
    endfunction

    initial begin
        int burst;
        i_rst_n      = 1'b0;
        pt_if.valid  = 1'b0;
        pt_if.x_in   = '0;
        pt_if.y_in   = '0;
        pt_if.z_in   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset state: zero centre, zero angles, so points come back unchanged.
        send_point(PT_MAX, PT_MIN, '0);
        send_point(PT_MIN, PT_MAX, -24'sd1);
        send_point(24'sd1, -24'sd1, PT_MAX);
        settle();

        // X and Y centre sums at their extremes, quarter turn about X with junk above
        // the angle field.
        write_reg(REG_CSUM_X,  CSUM_TOP);
        write_reg(REG_CSUM_Y,  CSUM_BOTTOM);
        write_reg(REG_CSUM_Z,  CSUM_ZERO);
        write_reg(REG_ANGLE_X, {{(CFG_DATA_W - ANGLE_BITS){1'b1}},
                                ANGLE_BITS'(ANGLE_QUARTER)});
        write_reg(REG_ANGLE_Y, '0);
        write_reg(REG_ANGLE_Z, '0);
        send_point(PT_MAX, PT_MAX, PT_MAX);
        send_point(PT_MIN, PT_MIN, PT_MIN);
        send_point('0, '0, '0);
        settle();

        // Half turn about Y and an eighth about Z: rail points clip here.
        write_reg(REG_CSUM_X,  CSUM_ZERO);
        write_reg(REG_CSUM_Y,  CSUM_ZERO);
        write_reg(REG_ANGLE_X, '0);
        write_reg(REG_ANGLE_Y, CFG_DATA_W'(2 * ANGLE_QUARTER));
        write_reg(REG_ANGLE_Z, CFG_DATA_W'(ANGLE_QUARTER / 2));
        send_point(PT_MAX, PT_MAX, '0);
        send_point(PT_MIN, PT_MIN, PT_MIN);
        send_point(24'sd1000, -24'sd1000, 24'sd123);
        settle();

        // Spare indexes must leave everything alone; all angles one step short
        // of a full turn; X centre at -1, Z centre above the stated range.
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        write_reg(REG_ANGLE_X, '1);
        write_reg(REG_ANGLE_Y, '1);
        write_reg(REG_ANGLE_Z, '1);
        write_reg(REG_CSUM_X,  CSUM_MINUS1);
        write_reg(REG_CSUM_Z,  CSUM_ABOVE);
        send_point(PT_MAX, PT_MIN, PT_MAX);
        send_point(PT_MIN, PT_MAX, PT_MIN);
        send_point(-24'sd1, 24'sd1, -24'sd1);
        settle();

        // Three quarters and either side of a quarter turn.
        write_reg(REG_CSUM_X,  CSUM_ZERO);
        write_reg(REG_CSUM_Z,  CSUM_ZERO);
        write_reg(REG_ANGLE_X, CFG_DATA_W'(3 * ANGLE_QUARTER));
        write_reg(REG_ANGLE_Y, CFG_DATA_W'(ANGLE_QUARTER - 1));
        write_reg(REG_ANGLE_Z, CFG_DATA_W'(ANGLE_QUARTER + 1));
        send_point(PT_MAX, '0, PT_MIN);
        send_point(24'sd256, 24'sd512, -24'sd768);
        send_point(PT_MIN, PT_MAX, '0);
        settle();

        // Random phases: fresh settings (some registers left as they were),
        // then a burst of points. The calm stretch sits in the middle.
        points_sent = 0;
        while (points_sent < RANDOM_ITEMS) begin
            for (int r = REG_CSUM_X; r <= REG_ANGLE_Z; r++) begin
                if ($urandom_range(0, 99) < 65) begin
                    write_reg(CFG_IDX_W'(r),
                              (r < REG_ANGLE_X) ? rand_csum() : rand_angle_word());
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            end
            src_idle_en = !(points_sent >= CALM_FROM && points_sent < CALM_TO);
            snk_idle_en = src_idle_en;
            burst = $urandom_range(20, 100);
            @(negedge i_clk);
            repeat (burst) send_point(rand_coord(), rand_coord(), rand_coord());
            settle();
        end

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        // Leftover expectations count against the block as well.
        if (fail_count == 0 && outstanding == 0) begin
            $display("rotate_point_about_center_xyz_top test passed");
        end else begin
            $display("rotate_point_about_center_xyz_top test failed");
        end
        $finish;
    end

endmodule
